### rtl/core/lhfp_pkg.sv
package lhfp_pkg;

	// Fixed-point unit: 65535 stands for 1.0.
	localparam logic [15:0] FULL = 16'hFFFF;

	// Step gain, floor(0.06 * 65535), applied to speed in Q4.12.
	localparam logic [11:0] STEP_K = 12'd3932;

	// Default number of LEDs held in the state memory.
	localparam int MAX_LEDS_DEF = 256;

	// Command codes carried in tuser.
	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_SPEED      = 1'b0;
	localparam logic CFG_HEAT_FLOOR = 1'b1;

	// Configuration reset values.
	localparam logic [15:0] SPEED_RST      = 16'd4096;
	localparam logic [15:0] HEAT_FLOOR_RST = 16'd16384;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPW         = $clog2(QUEUE_DEPTH);

	// One classified item as it waits in the queue.
	typedef struct packed {
		logic        seed;
		logic [7:0]  idx;
		logic [15:0] rand_target;
		logic [15:0] rand_heat;
	} item_t;

	// Updated heat of one step item, handed to the color pipeline.
	typedef struct packed {
		logic        valid;
		logic [7:0]  idx;
		logic [15:0] heat;
	} heat_msg_t;

endpackage

### rtl/core/lhfp_front.sv
module lhfp_front
	import lhfp_pkg::*;
#(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  logic        tvalid,
	output logic        tready,
	input  logic [39:0] tdata,   // led_index, rand_target, rand_heat
	input  logic [0:0]  tuser,   // cmd
	input  logic        q_full,
	output logic        push,
	output item_t       item
);

	logic [7:0] led_idx;
	logic       in_range;

	// Unpack the transaction and decode the command.
	assign led_idx          = tdata[7:0];
	assign item.idx         = led_idx;
	assign item.rand_target = tdata[23:8];
	assign item.rand_heat   = tdata[39:24];
	assign item.seed        = (tuser[0] == CMD_SEED);

	// An LED beyond the memory has no effect, so such items are dropped here.
	assign in_range = (32'(led_idx) < 32'(MAX_LEDS));

	assign tready = !q_full;
	assign push   = tvalid && !q_full && in_range;

endmodule

### rtl/core/lhfp_queue.sv
module lhfp_queue
	import lhfp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	item_t          slot_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   count_q;

	assign full  = (count_q == (QPW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/core/lhfp_back.sv
module lhfp_back
	import lhfp_pkg::*;
#(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        q_empty,
	input  item_t       q_item,
	output logic        pop,
	input  logic [15:0] speed,
	output heat_msg_t   msg
);

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	typedef struct packed {
		logic [15:0] heat;
		logic [15:0] tgt;
	} entry_t;

	entry_t        mem [MAX_LEDS];
	logic [27:0]   step_prod;
	logic [15:0]   step_q;
	logic          v_s1;
	item_t         item_s1;
	logic          v_s2;
	item_t         item_s2;
	entry_t        rd_s2;
	logic          v_s3;
	logic [7:0]    idx_s3;
	logic [15:0]   heat_s3;
	logic          byp_valid_q;
	logic [AW-1:0] byp_addr_q;
	entry_t        byp_data_q;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] addr_s2;
	entry_t        cur;
	entry_t        nxt;
	logic [15:0]   up_gap;
	logic [15:0]   down_gap;

	// Heat step per item, recomputed from speed every cycle.
	assign step_prod = 28'(speed) * 28'(STEP_K);

	always_ff @(posedge clk) begin
		step_q <= step_prod[27:12];
	end

	assign pop     = adv && !q_empty;
	assign addr_s1 = AW'(item_s1.idx);
	assign addr_s2 = AW'(item_s2.idx);
	assign msg     = '{v_s3, idx_s3, heat_s3};

	// Stage valid bits and bypass flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			byp_valid_q <= 1'b0;
			v_s3        <= 1'b0;
		end else if (adv) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			byp_valid_q <= v_s2;
			v_s3        <= v_s2 && !item_s2.seed;
		end
	end

	// Stage payload, state read and the last write kept for the bypass.
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1    <= q_item;
			item_s2    <= item_s1;
			rd_s2      <= mem[addr_s1];
			byp_addr_q <= addr_s2;
			byp_data_q <= nxt;
			idx_s3     <= item_s2.idx;
			heat_s3    <= nxt.heat;
		end
	end

	// State write-back of the item in stage two.
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			mem[addr_s2] <= nxt;
		end
	end

	// The item just ahead may have written this entry after it was read.
	assign cur = (byp_valid_q && (byp_addr_q == addr_s2)) ? byp_data_q : rd_s2;

	assign up_gap   = cur.tgt - cur.heat;
	assign down_gap = cur.heat - cur.tgt;

	// A seed loads heat and target; a step moves heat one step toward the target, or picks a new target when close.
	always_comb begin
		nxt = cur;
		if (item_s2.seed) begin
			nxt.heat = item_s2.rand_heat;
			nxt.tgt  = item_s2.rand_target;
		end else if ((cur.tgt > cur.heat) && (up_gap > step_q)) begin
			nxt.heat = cur.heat + step_q;
		end else if ((cur.heat > cur.tgt) && (down_gap > step_q)) begin
			nxt.heat = cur.heat - step_q;
		end else begin
			nxt.tgt = item_s2.rand_target;
		end
	end

endmodule

### rtl/core/lhfp_palette.sv
module lhfp_palette
	import lhfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  heat_msg_t   msg,
	input  logic [15:0] heat_floor,
	output logic        adv,
	output logic        tvalid,
	input  logic        tready,
	output logic [31:0] tdata     // pixel_index, red, green, blue
);

	localparam logic [25:0] RED_MUL   = 26'd765;
	localparam logic [26:0] GREEN_MUL = 27'd187;
	localparam logic [23:0] BLUE_MUL  = 24'd51;
	localparam logic [19:0] GREEN_THR = 20'd262140;   // 4 * 65535
	localparam logic [20:0] BLUE_THR  = 21'd1114095;  // 17 * 65535

	// Floor of x / 65535 for x below 65535 * 65536.
	function automatic logic [15:0] div_full(input logic [31:0] x);
		logic [15:0] q0;
		logic [16:0] sum;
		begin
			q0       = x[31:16];
			sum      = {1'b0, x[15:0]} + {1'b0, q0};
			div_full = q0 + 16'(sum >= 17'(FULL));
		end
	endfunction

	logic        v_s4, v_s5, v_s6, v_s7;
	logic [7:0]  idx_s4, idx_s5, idx_s6, idx_s7;
	logic [31:0] x_s4;
	logic [15:0] h_s5;
	logic [25:0] rp_s6;
	logic [18:0] gd_s6;
	logic [17:0] bd_s6;
	logic [7:0]  red_s7;
	logic [23:0] gm_s7;
	logic [21:0] bm_s7;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic [15:0] lift_q;
	logic [16:0] h_sum;
	logic [19:0] h10;
	logic [20:0] h20;
	logic [15:0] red_q16;
	logic [26:0] gp;
	logic [23:0] bp;
	logic [15:0] green_q16;
	logic [15:0] blue_q16;

	assign adv    = !out_valid_q || tready;
	assign tvalid = out_valid_q;
	assign tdata  = out_data_q;

	// Lift by the floor: h = floor + (65535 - floor) * heat / 65535.
	assign lift_q = div_full(x_s4);
	assign h_sum  = {1'b0, heat_floor} + {1'b0, lift_q};

	// Palette thresholds scaled to integers.
	assign h10 = 20'(h_s5) * 20'd10;
	assign h20 = 21'(h_s5) * 21'd20;

	// Red saturates at full drive.
	assign red_q16 = div_full(32'(rp_s6));
	assign gp      = 27'(gd_s6) * GREEN_MUL;
	assign bp      = 24'(bd_s6) * BLUE_MUL;

	assign green_q16 = div_full(32'(gm_s7));
	assign blue_q16  = div_full(32'(bm_s7));

	// Stage valid bits and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s4        <= msg.valid;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	// Color arithmetic, spread over the stage registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s4 <= msg.idx;
			x_s4   <= 32'(FULL - heat_floor) * 32'(msg.heat);

			idx_s5 <= idx_s4;
			h_s5   <= h_sum[15:0];

			idx_s6 <= idx_s5;
			rp_s6  <= 26'(h_s5) * RED_MUL;
			gd_s6  <= (h10 > GREEN_THR) ? 19'(h10 - GREEN_THR) : '0;
			bd_s6  <= (h20 > BLUE_THR) ? 18'(h20 - BLUE_THR) : '0;

			idx_s7 <= idx_s6;
			red_s7 <= (red_q16 > 16'd255) ? 8'hFF : red_q16[7:0];
			gm_s7  <= gp[26:3];
			bm_s7  <= bp[23:2];

			out_data_q <= {blue_q16[7:0], green_q16[7:0], red_s7, idx_s7};
		end
	end

endmodule

### rtl/core/led_heat_flicker_palette_top.sv
// Channel     Dir  Handshake                      Payload
// s_axis      in   s_axis_tvalid / s_axis_tready  tdata: led_index, rand_target, rand_heat;
//                                                 tuser: cmd
// m_axis      out  m_axis_tvalid / m_axis_tready  tdata: pixel_index, red, green, blue
// cfg         in   cfg_we (no wait)               cfg_index, cfg_data
//
// One item is accepted per cycle while the queue is not full. A step item's pixel passes
// through the queue, stage one, the state read, the update and five color stages.
// Reset empties the queue, clears the stage valid bits and loads the register defaults;
// the LED state memory is not cleared and an LED must be seeded before it is stepped.
// A stalled output freezes the back pipeline; the four-entry queue keeps taking items
// until it fills, and then s_axis_tready falls.
module led_heat_flicker_palette_top
	import lhfp_pkg::*;
#(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // led_index, rand_target, rand_heat
	input  logic [0:0]  s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // pixel_index, red, green, blue
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] speed_q;
	logic [15:0] heat_floor_q;
	logic        push;
	item_t       push_item;
	logic        pop;
	item_t       q_head;
	logic        q_full;
	logic        q_empty;
	logic        adv;
	heat_msg_t   heat_msg;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q      <= SPEED_RST;
			heat_floor_q <= HEAT_FLOOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPEED:      speed_q      <= cfg_data;
				CFG_HEAT_FLOOR: heat_floor_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	lhfp_front #(
		.MAX_LEDS (MAX_LEDS)
	) u_front (
		.tvalid (s_axis_tvalid),
		.tready (s_axis_tready),
		.tdata  (s_axis_tdata),
		.tuser  (s_axis_tuser),
		.q_full (q_full),
		.push   (push),
		.item   (push_item)
	);

	lhfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	lhfp_back #(
		.MAX_LEDS (MAX_LEDS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.q_empty (q_empty),
		.q_item  (q_head),
		.pop     (pop),
		.speed   (speed_q),
		.msg     (heat_msg)
	);

	lhfp_palette u_palette (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (heat_msg),
		.heat_floor (heat_floor_q),
		.adv        (adv),
		.tvalid     (m_axis_tvalid),
		.tready     (m_axis_tready),
		.tdata      (m_axis_tdata)
	);

endmodule

### test/led_heat_flicker_palette_top_tb.sv
module led_heat_flicker_palette_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lhfp_pkg::*;

	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 105;
	localparam int NUM_PHASES     = 6;
	localparam int IDLE_PCT       = 19;

	// One pixel as it leaves the block.
	typedef struct packed {
		logic [7:0] led;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// One directed transaction; a typed row carries its pixel written out by hand.
	typedef struct packed {
		logic        cmd;
		logic [7:0]  led;
		logic [15:0] tgt;
		logic [15:0] heat;
		logic        typed;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} stim_row_t;

	localparam int NUM_ROWS = 22;
	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// Cold LED at rest: heat equals target, so only the floor shows.
		'{CMD_SEED, 8'd0,   16'h0000, 16'h0000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'd0,   16'hFFFF, 16'h0000, 1'b1, 8'd191, 8'd0,   8'd0},
		'{CMD_STEP, 8'd0,   16'h0000, 16'hFFFF, 1'b0, 8'd0,   8'd0,   8'd0},
		// Hottest LED at rest: every channel at its ceiling.
		'{CMD_SEED, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'd255, 16'h0000, 16'h1234, 1'b1, 8'd255, 8'd140, 8'd38},
		'{CMD_STEP, 8'd255, 16'hFFFF, 16'h0000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'd255, 16'h8000, 16'h0000, 1'b0, 8'd0,   8'd0,   8'd0},
		// Gap exactly one step above: the target is replaced.
		'{CMD_SEED, 8'd1,   16'd4932, 16'd1000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'd1,   16'h1234, 16'h0000, 1'b0, 8'd0,   8'd0,   8'd0},
		// Gap one above a step: heat moves up, then the target is replaced.
		'{CMD_SEED, 8'd2,   16'd4933, 16'd1000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'd2,   16'h4321, 16'h0000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'd2,   16'hC000, 16'h0000, 1'b0, 8'd0,   8'd0,   8'd0},
		// Same two cases below the heat.
		'{CMD_SEED, 8'd3,   16'd1068, 16'd5000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'd3,   16'h0FF0, 16'h0000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_SEED, 8'd4,   16'd1067, 16'd5000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'd4,   16'hF00F, 16'h0000, 1'b0, 8'd0,   8'd0,   8'd0},
		// Alternating bit patterns on every field.
		'{CMD_SEED, 8'hAA,  16'h5555, 16'hAAAA, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'hAA,  16'hAAAA, 16'h5555, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_SEED, 8'h55,  16'hAAAA, 16'h5555, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'h55,  16'h5555, 16'hAAAA, 1'b0, 8'd0,   8'd0,   8'd0},
		// Reseeding an LED overrides its old state.
		'{CMD_SEED, 8'd0,   16'h0000, 16'hFFFF, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_STEP, 8'd0,   16'hFFFF, 16'h0000, 1'b0, 8'd0,   8'd0,   8'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // led_index, rand_target, rand_heat
	logic [0:0]  s_axis_tuser = '0;   // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // pixel_index, red, green, blue
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_SPEED;
	logic [15:0] cfg_data = '0;

	// Local copy of the LED state and the registers.
	logic [15:0] heat_mem [256];
	logic [15:0] target_mem [256];
	bit          seeded [256];
	logic [15:0] speed_reg = SPEED_RST;
	logic [15:0] heat_floor_reg = HEAT_FLOOR_RST;

	pixel_t pending_pixels [$];
	pixel_t oldest_pixel;
	int     errors = 0;
	int     quiet_cycles = 0;
	bit     calm = 1'b0;

	led_heat_flicker_palette_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// Lift the heat by the floor and map it onto the black-red-orange ramp.
	function automatic pixel_t heat_color(input logic [7:0] led, input logic [15:0] heat);
		logic [63:0] unit;
		logic [63:0] h;
		logic [63:0] rv;
		pixel_t px;
		unit = 64'(FULL);
		h = 64'(heat_floor_reg) + (64'(FULL - heat_floor_reg) * 64'(heat)) / unit;
		rv = (h * 765) / unit;
		px.led = led;
		px.red = (rv > 255) ? 8'd255 : rv[7:0];
		if (10 * h > 4 * unit)
			px.green = 8'(((10 * h - 4 * unit) * 561) / (24 * unit));
		else
			px.green = 8'd0;
		if (100 * h > 85 * unit)
			px.blue = 8'(((100 * h - 85 * unit) * 255) / (100 * unit));
		else
			px.blue = 8'd0;
		return px;
	endfunction

	// Apply one accepted transaction to the LED state; a step yields a pixel.
	function automatic bit advance_led(input logic cmd, input logic [7:0] led,
			input logic [15:0] tgt_in, input logic [15:0] heat_in, output pixel_t px);
		int unsigned step_sz;
		int unsigned heat;
		int unsigned tgt;
		if (cmd == CMD_SEED) begin
			heat_mem[led] = heat_in;
			target_mem[led] = tgt_in;
			seeded[led] = 1'b1;
			return 1'b0;
		end
		step_sz = (32'(speed_reg) * 32'(STEP_K)) >> 12;
		heat = heat_mem[led];
		tgt = target_mem[led];
		if (tgt > heat && tgt - heat > step_sz)
			heat = heat + step_sz;
		else if (heat > tgt && heat - tgt > step_sz)
			heat = heat - step_sz;
		else
			tgt = tgt_in;
		heat_mem[led] = 16'(heat);
		target_mem[led] = 16'(tgt);
		px = heat_color(led, 16'(heat));
		return 1'b1;
	endfunction

	// Offer one transaction, idling at random first outside the calm stretch, and record its pixel once accepted.
	task automatic send_item(input logic cmd, input logic [7:0] led, input logic [15:0] tgt,
			input logic [15:0] heat, input bit typed, input pixel_t typed_px);
		pixel_t px;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {heat, tgt, led};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (advance_led(cmd, led, tgt, heat, px))
			pending_pixels.push_back(typed ? typed_px : px);
	endtask

	// Register write; the caller lowers the write enable afterwards.
	task automatic write_reg(input logic index, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		if (index == CFG_SPEED)
			speed_reg = value;
		else
			heat_floor_reg = value;
	endtask

	// Wait until every pixel has come and the pipeline has gone quiet.
	task automatic drain();
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random traffic, mostly steps on a small set of LEDs so heat walks to its targets.
	task automatic random_phase(input int count);
		logic [7:0]  led;
		logic [15:0] tgt;
		logic [15:0] heat;
		logic        cmd;
		for (int n = 0; n < count; n++) begin
			led = ($urandom_range(99) < 70) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
			cmd = (!seeded[led] || $urandom_range(99) < 20) ? CMD_SEED : CMD_STEP;
			tgt = 16'($urandom_range(65535));
			heat = 16'($urandom_range(65535));
			if ($urandom_range(9) == 0)
				tgt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			if ($urandom_range(9) == 0)
				heat = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			send_item(cmd, led, tgt, heat, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// The receiver stalls at random except in the calm stretch.
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// Each pixel transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel: tdata 0x%08h", m_axis_tdata);
				errors++;
			end else begin
				oldest_pixel = pending_pixels.pop_front();
				if (m_axis_tdata[7:0] !== oldest_pixel.led) begin
					$error("pixel_index: expected %0d, got %0d", oldest_pixel.led,
						m_axis_tdata[7:0]);
					errors++;
				end
				if (m_axis_tdata[15:8] !== oldest_pixel.red) begin
					$error("red: expected %0d, got %0d", oldest_pixel.red, m_axis_tdata[15:8]);
					errors++;
				end
				if (m_axis_tdata[23:16] !== oldest_pixel.green) begin
					$error("green: expected %0d, got %0d", oldest_pixel.green,
						m_axis_tdata[23:16]);
					errors++;
				end
				if (m_axis_tdata[31:24] !== oldest_pixel.blue) begin
					$error("blue: expected %0d, got %0d", oldest_pixel.blue,
						m_axis_tdata[31:24]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("led_heat_flicker_palette_top_tb failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] speed_val;
		logic [15:0] floor_val;
		pixel_t      row_px;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run with the reset register values.
		for (int i = 0; i < NUM_ROWS; i++) begin
			row_px = '{DIRECTED_ROWS[i].led, DIRECTED_ROWS[i].red,
				DIRECTED_ROWS[i].green, DIRECTED_ROWS[i].blue};
			send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].led, DIRECTED_ROWS[i].tgt,
				DIRECTED_ROWS[i].heat, DIRECTED_ROWS[i].typed, row_px);
		end
		s_axis_tvalid <= 1'b0;

		// Random phases, each under its own register setting.
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
				0: begin
					speed_val = 16'h0000;
					floor_val = 16'h0000;
				end
				1: begin
					speed_val = 16'hFFFF;
					floor_val = 16'hFFFF;
				end
				2: begin
					speed_val = SPEED_RST;
					floor_val = HEAT_FLOOR_RST;
				end
				3: begin
					speed_val = 16'hFFFF;
					floor_val = 16'h0000;
				end
				4: begin
					speed_val = 16'h0000;
					floor_val = 16'hFFFF;
				end
				default: begin
					speed_val = 16'($urandom_range(65535));
					floor_val = 16'($urandom_range(65535));
				end
			endcase
			write_reg(CFG_SPEED, speed_val);
			write_reg(CFG_HEAT_FLOOR, floor_val);
			cfg_we <= 1'b0;
			calm = (p == 2);
			random_phase(PHASE_ITEMS);
		end
		calm = 1'b0;

		drain();
		if (pending_pixels.size() != 0) begin
			$error("%0d pixels never arrived", pending_pixels.size());
			errors++;
		end
		if (errors == 0)
			$display("led_heat_flicker_palette_top_tb passed");
		else
			$display("led_heat_flicker_palette_top_tb failed");
		$finish;
	end

endmodule
